// ===== hw/rtl/qpht_pkg.sv =====
`timescale 1ns / 1ps

package qpht_pkg;

  localparam int KEY_W     = 31;
  localparam int REG_W     = 15;
  localparam int SLOT_FW   = 14;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam int TABLE_DEPTH_DEF = 16384;

  localparam logic [REG_W-1:0] TABLE_SIZE_RST  = 15'd10007;
  localparam logic [REG_W-1:0] PROBE_LIMIT_RST = 15'd8006;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_SIZE  = 1'b0,
    CFG_PROBE_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    FUNC_INSERT = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED      = 2'd0,
    ST_INSERT_FAILED = 2'd1,
    ST_FOUND         = 2'd2,
    ST_NOT_FOUND     = 2'd3
  } status_t;

endpackage

// ===== hw/rtl/qpht_if.sv =====
`timescale 1ns / 1ps

interface qpht_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [qpht_pkg::KEY_W-1:0]   key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

interface qpht_out_if;
  logic                            valid;
  logic                            ready;
  logic [qpht_pkg::STATUS_W-1:0]   status;
  logic [qpht_pkg::SLOT_FW-1:0]    slot;
  logic [qpht_pkg::REG_W-1:0]      probe_count;

  modport source (output valid, output status, output slot, output probe_count, input ready);
  modport sink   (input valid, input status, input slot, input probe_count, output ready);
endinterface

// ===== hw/rtl/quadratic_probe_hash_table.sv =====
`timescale 1ns / 1ps
// Each item is accepted, then the key is reduced mod the table size (one key bit a cycle
// through the shared add-mod unit), then each probe is a memory read and then a check, and the
// result lands in the output register. One item at a time.
// Reset (synchronous, rst_n low) clears control state and loads the register defaults, then a
// clearing pass empties every slot before the first item is accepted.
module quadratic_probe_hash_table #(
  parameter int TABLE_DEPTH = qpht_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  qpht_in_if.sink                           in_chan,
  qpht_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [qpht_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qpht_pkg::REG_W-1:0]        cfg_wdata
);

  localparam int KEY_W     = qpht_pkg::KEY_W;
  localparam int REG_W     = qpht_pkg::REG_W;
  localparam int SLOT_W    = $clog2(TABLE_DEPTH);
  localparam int SIZE_W    = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W   = KEY_W + 1;
  localparam int BIT_CNT_W = $clog2(KEY_W);

  localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT  = BIT_CNT_W'(KEY_W - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_READ,
    S_CHECK
  } state_t;

  // Control and datapath registers
  state_t                 state_r, state_nxt;
  logic [REG_W-1:0]       table_size_r, table_size_nxt;
  logic [REG_W-1:0]       probe_limit_r, probe_limit_nxt;
  logic [SLOT_W-1:0]      clr_r, clr_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [KEY_W-1:0]       sh_r, sh_nxt;
  logic                   func_r, func_nxt;
  logic [SLOT_W-1:0]      pos_r, pos_nxt;
  logic [SLOT_W-1:0]      delta_r, delta_nxt;
  logic [REG_W-1:0]       count_r, count_nxt;

  // Output register
  logic                           out_valid_r, out_valid_nxt;
  qpht_pkg::status_t              out_status_r, out_status_nxt;
  logic [qpht_pkg::SLOT_FW-1:0]   out_slot_r, out_slot_nxt;
  logic [REG_W-1:0]               out_count_r, out_count_nxt;

  // Slot memory: bit KEY_W is the occupied mark, the rest the stored key
  logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
  logic                   mem_we;
  logic [SLOT_W-1:0]      mem_waddr;
  logic [ENTRY_W-1:0]     mem_wdata;
  logic [ENTRY_W-1:0]     rd_data_r;

  // Effective table size and probe limit
  logic [SIZE_W-1:0]      size_eff;
  logic [REG_W-1:0]       limit_eff;
  logic [SLOT_W-1:0]      c3, c4;

  always_comb begin
    if (table_size_r == '0) begin
      size_eff = SIZE_W'(1);
    end else if (32'(table_size_r) > 32'(TABLE_DEPTH)) begin
      size_eff = SIZE_W'(TABLE_DEPTH);
    end else begin
      size_eff = SIZE_W'(table_size_r);
    end
  end

  assign limit_eff = (probe_limit_r == '0) ? REG_W'(1) : probe_limit_r;

  // First probe step (3) and its growth per probe (4), both reduced mod the table size.
  // The gap between probes i and i+1 is 4*i + 3.
  always_comb begin
    if (32'(size_eff) > 32'd4) begin
      c3 = SLOT_W'(3);
      c4 = SLOT_W'(4);
    end else if (32'(size_eff) == 32'd4) begin
      c3 = SLOT_W'(3);
      c4 = '0;
    end else if (32'(size_eff) == 32'd3) begin
      c3 = '0;
      c4 = SLOT_W'(1);
    end else if (32'(size_eff) == 32'd2) begin
      c3 = SLOT_W'(1);
      c4 = '0;
    end else begin
      c3 = '0;
      c4 = '0;
    end
  end

  // Shared add-mod unit: (a + b + cin) mod size, with a and b already below size.
  // Serves the key reduction, the probe step growth and the slot advance in turn.
  logic [SLOT_W-1:0]  am_a, am_b, am_res;
  logic               am_cin;
  logic [SLOT_W:0]    am_sum;
  logic [SLOT_W:0]    am_size;

  always_comb begin
    unique case (state_r)
      S_REDUCE: begin
        am_a   = pos_r;
        am_b   = pos_r;
        am_cin = sh_r[KEY_W-1];
      end
      S_READ: begin
        am_a   = delta_r;
        am_b   = c4;
        am_cin = 1'b0;
      end
      default: begin
        am_a   = pos_r;
        am_b   = delta_r;
        am_cin = 1'b0;
      end
    endcase
  end

  assign am_size = (SLOT_W+1)'(size_eff);
  assign am_sum  = {1'b0, am_a} + {1'b0, am_b} + (SLOT_W+1)'(am_cin);
  assign am_res  = (am_sum >= am_size) ? SLOT_W'(am_sum - am_size) : SLOT_W'(am_sum);

  // Probe check
  logic               slot_empty;
  logic               key_match;
  logic               last_probe;
  logic               out_free;
  logic               op_done;
  logic               op_write;
  qpht_pkg::status_t  res_status;
  logic               res_hit;

  assign slot_empty = ~rd_data_r[KEY_W];
  assign key_match  = (rd_data_r[KEY_W-1:0] == key_r);
  assign last_probe = (count_r == limit_eff);
  assign out_free   = ~out_valid_r | out_chan.ready;

  always_comb begin
    op_done    = 1'b0;
    op_write   = 1'b0;
    res_hit    = 1'b0;
    res_status = qpht_pkg::ST_NOT_FOUND;
    if (func_r == qpht_pkg::FUNC_INSERT) begin
      if (slot_empty) begin
        op_done    = 1'b1;
        op_write   = 1'b1;
        res_hit    = 1'b1;
        res_status = qpht_pkg::ST_INSERTED;
      end else if (last_probe) begin
        op_done    = 1'b1;
        res_status = qpht_pkg::ST_INSERT_FAILED;
      end
    end else begin
      if (slot_empty) begin
        op_done    = 1'b1;
        res_status = qpht_pkg::ST_NOT_FOUND;
      end else if (key_match) begin
        op_done    = 1'b1;
        res_hit    = 1'b1;
        res_status = qpht_pkg::ST_FOUND;
      end else if (last_probe) begin
        op_done    = 1'b1;
        res_status = qpht_pkg::ST_NOT_FOUND;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    table_size_nxt  = table_size_r;
    probe_limit_nxt = probe_limit_r;
    clr_nxt         = clr_r;
    bit_cnt_nxt     = bit_cnt_r;
    key_nxt         = key_r;
    sh_nxt          = sh_r;
    func_nxt        = func_r;
    pos_nxt         = pos_r;
    delta_nxt       = delta_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r & ~out_chan.ready;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_count_nxt   = out_count_r;
    mem_we          = 1'b0;
    mem_waddr       = pos_r;
    mem_wdata       = {1'b1, key_r};

    // Configuration writes land whenever they come; the user keeps them to idle time
    if (cfg_we) begin
      unique case (cfg_index)
        qpht_pkg::CFG_TABLE_SIZE:  table_size_nxt  = cfg_wdata;
        qpht_pkg::CFG_PROBE_LIMIT: probe_limit_nxt = cfg_wdata;
      endcase
    end

    unique case (state_r)
      S_CLEAR: begin
        // Empty one slot a cycle
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + SLOT_W'(1);
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_chan.valid) begin
          key_nxt     = in_chan.key;
          sh_nxt      = in_chan.key;
          func_nxt    = in_chan.func;
          pos_nxt     = '0;
          bit_cnt_nxt = '0;
          count_nxt   = '0;
          delta_nxt   = c3;
          state_nxt   = S_REDUCE;
        end
      end
      S_REDUCE: begin
        // Shift in one key bit, MSB first: rem = (2*rem + bit) mod size
        pos_nxt     = am_res;
        sh_nxt      = {sh_r[KEY_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + BIT_CNT_W'(1);
        if (bit_cnt_r == LAST_BIT) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // Memory read of pos_r is in flight; grow the step for the probe after this one
        count_nxt = count_r + REG_W'(1);
        if (count_r != '0) begin
          delta_nxt = am_res;
        end
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (op_done) begin
          // Hold here until the output register is free
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = res_status;
            out_slot_nxt   = res_hit ? qpht_pkg::SLOT_FW'(pos_r) : '0;
            out_count_nxt  = count_r;
            mem_we         = op_write;
            state_nxt      = S_IDLE;
          end
        end else begin
          pos_nxt   = am_res;
          state_nxt = S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      table_size_r  <= qpht_pkg::TABLE_SIZE_RST;
      probe_limit_r <= qpht_pkg::PROBE_LIMIT_RST;
      clr_r         <= '0;
      bit_cnt_r     <= '0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      table_size_r  <= table_size_nxt;
      probe_limit_r <= probe_limit_nxt;
      clr_r         <= clr_nxt;
      bit_cnt_r     <= bit_cnt_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
      key_r         <= key_nxt;
      sh_r          <= sh_nxt;
      func_r        <= func_nxt;
      pos_r         <= pos_nxt;
      delta_r       <= delta_nxt;
      out_status_r  <= out_status_nxt;
      out_slot_r    <= out_slot_nxt;
      out_count_r   <= out_count_nxt;
    end
  end

  // Single-port-write, registered-read slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[pos_r];
  end

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.slot        = out_slot_r;
  assign out_chan.probe_count = out_count_r;

endmodule

// ===== hw/rtl/qpht_checker.sv =====
`timescale 1ns / 1ps

module qpht_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [qpht_pkg::STATUS_W-1:0]   out_status,
  input logic [qpht_pkg::SLOT_FW-1:0]    out_slot,
  input logic [qpht_pkg::REG_W-1:0]      out_probe_count
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot)
      && $stable(out_probe_count))
    else $error("stalled result changed");

  // One item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after accept");

  // Clearing pass blocks input after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready during clear");

  // Misses report slot zero
  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == qpht_pkg::ST_INSERT_FAILED
      || out_status == qpht_pkg::ST_NOT_FOUND) |-> out_slot == '0)
    else $error("miss with nonzero slot");

  // Every operation probes at least once
  a_probe_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_probe_count != '0)
    else $error("zero probe count");

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_slot        (out_chan.slot),
  .out_probe_count (out_chan.probe_count)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int KEY_W     = qpht_pkg::KEY_W;
  localparam int REG_W     = qpht_pkg::REG_W;
  localparam int SLOT_FW   = qpht_pkg::SLOT_FW;
  localparam int CFG_IDX_W = qpht_pkg::CFG_IDX_W;

  localparam int DEPTH              = qpht_pkg::TABLE_DEPTH_DEF;
  localparam int RANDOM_ITEMS       = 930;
  // Extra idle time at the end, to catch any stray late result.
  localparam int DRAIN_CYCLES       = 96;
  localparam int LONG_HOLD_CYCLES   = 600;
  localparam int HOLD_AFTER_RESULTS = 150;
  localparam int KNOWN_KEYS_MAX     = 512;

  // One result as the block reports it.
  typedef struct packed {
    qpht_pkg::status_t  status;
    logic [SLOT_FW-1:0] slot;
    logic [REG_W-1:0]   probe_count;
  } lookup_result_t;

  typedef enum logic {
    ROW_CFG,
    ROW_OP
  } row_kind_t;

  // One line of the directed table: either a settings change or one item,
  // the latter optionally with its result written out by hand.
  typedef struct packed {
    row_kind_t        kind;
    qpht_pkg::func_t  func;
    logic [KEY_W-1:0] key;
    logic [REG_W-1:0] size_val;
    logic [REG_W-1:0] limit_val;
    logic             typed;
    lookup_result_t   want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  qpht_in_if  in_if ();
  qpht_out_if out_if ();

  quadratic_probe_hash_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the table and its settings, kept in step with every accepted item.
  bit               shadow_occupied [DEPTH];
  logic [KEY_W-1:0] shadow_keys     [DEPTH];
  logic [REG_W-1:0] shadow_size;
  logic [REG_W-1:0] shadow_limit;

  lookup_result_t   pending_results [$];
  logic [KEY_W-1:0] inserted_keys [$];

  int error_count;
  int items_sent;
  int results_checked;
  int phases_run;
  int burst_left;
  int status_seen [4];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Zero acts as one slot; anything above the storage depth is clamped to it.
  function automatic int unsigned effective_size();
    if (shadow_size == 0) return 1;
    if (shadow_size > DEPTH) return DEPTH;
    return shadow_size;
  endfunction

  // Walk the quadratic probe sequence of one item, commit an insert to the
  // shadow table, and return the result the block must report.
  function automatic lookup_result_t apply_probe(qpht_pkg::func_t f, logic [KEY_W-1:0] k);
    lookup_result_t   r;
    int unsigned      n;
    int unsigned      lim;
    int unsigned      i;
    int unsigned      j;
    longint unsigned  step;
    longint unsigned  pos;
    n   = effective_size();
    lim = (shadow_limit == 0) ? 1 : shadow_limit;
    r.status      = (f == qpht_pkg::FUNC_INSERT) ? qpht_pkg::ST_INSERT_FAILED
                                                 : qpht_pkg::ST_NOT_FOUND;
    r.slot        = '0;
    r.probe_count = '0;
    for (i = 0; i < lim; i++) begin
      step = i;
      pos  = k;
      pos  = pos + step + 2 * step * step;
      j    = 32'(pos % n);
      r.probe_count = REG_W'(i + 1);
      if (!shadow_occupied[j]) begin
        // An empty slot ends both operations; only an insert claims it.
        if (f == qpht_pkg::FUNC_INSERT) begin
          shadow_occupied[j] = 1'b1;
          shadow_keys[j]     = k;
          r.status           = qpht_pkg::ST_INSERTED;
          r.slot             = SLOT_FW'(j);
        end
        break;
      end
      if (f == qpht_pkg::FUNC_SEARCH && shadow_keys[j] == k) begin
        r.status = qpht_pkg::ST_FOUND;
        r.slot   = SLOT_FW'(j);
        break;
      end
    end
    return r;
  endfunction

  // Mix of key shapes: tiny ids, ids near the top of the range, ids that
  // land on the same home slot as each other, and plain random ones.
  function automatic logic [KEY_W-1:0] shaped_key();
    case ($urandom_range(0, 7))
      0:       return KEY_W'($urandom_range(0, 63));
      1:       return KEY_W'({KEY_W{1'b1}} - $urandom_range(0, 63));
      2:       return KEY_W'($urandom_range(0, 4000) * effective_size()
                             + $urandom_range(0, 2));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic stim_row_t op_row(qpht_pkg::func_t f, logic [KEY_W-1:0] k);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_OP;
    r.func = f;
    r.key  = k;
    return r;
  endfunction

  function automatic stim_row_t op_known(qpht_pkg::func_t f, logic [KEY_W-1:0] k,
                                         qpht_pkg::status_t st,
                                         logic [SLOT_FW-1:0] s, logic [REG_W-1:0] c);
    stim_row_t r;
    r       = op_row(f, k);
    r.typed = 1'b1;
    r.want  = '{st, s, c};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [REG_W-1:0] size_val,
                                        logic [REG_W-1:0] limit_val);
    stim_row_t r;
    r           = '0;
    r.kind      = ROW_CFG;
    r.size_val  = size_val;
    r.limit_val = limit_val;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one item; the sender works in bursts, so open a fresh burst with a
  // random gap when the current one runs out. Predict on acceptance.
  task automatic offer(qpht_pkg::func_t f, logic [KEY_W-1:0] k, logic typed,
                       lookup_result_t want);
    lookup_result_t predicted;
    int             gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.func  <= f;
    in_if.key   <= k;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted = apply_probe(f, k);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Drop valid and hold until every outstanding result has been taken.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write both registers back to back; the block is idle when this runs.
  task automatic write_settings(logic [REG_W-1:0] size_val, logic [REG_W-1:0] limit_val);
    cfg_we    <= 1'b1;
    cfg_index <= qpht_pkg::CFG_TABLE_SIZE;
    cfg_wdata <= size_val;
    @(posedge clk);
    cfg_index <= qpht_pkg::CFG_PROBE_LIMIT;
    cfg_wdata <= limit_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_size  = size_val;
    shadow_limit = limit_val;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    stim_row_t        directed_rows [25];
    logic [REG_W-1:0] size_val;
    logic [REG_W-1:0] limit_val;
    int               phase_items;
    int               random_sent;
    int               pick;
    qpht_pkg::func_t  f;
    logic [KEY_W-1:0] k;

    // Directed part. Rows with a hand-written result use the reset settings,
    // a one-slot table (zero size and zero limit both act as one), a full
    // one-slot table that fails after every allowed probe, and the top slot
    // of an oversized table and of a full-depth one. The rest go through the shadow model.
    directed_rows = '{
      op_known(qpht_pkg::FUNC_SEARCH, 31'd0, qpht_pkg::ST_NOT_FOUND, 14'd0, 15'd1),
      op_known(qpht_pkg::FUNC_INSERT, 31'd0, qpht_pkg::ST_INSERTED, 14'd0, 15'd1),
      op_known(qpht_pkg::FUNC_SEARCH, 31'd0, qpht_pkg::ST_FOUND, 14'd0, 15'd1),
      op_row(qpht_pkg::FUNC_INSERT, 31'd0),       // duplicate goes further down the chain
      op_row(qpht_pkg::FUNC_INSERT, 31'h7FFF_FFFF),
      op_row(qpht_pkg::FUNC_SEARCH, 31'h7FFF_FFFF),
      op_row(qpht_pkg::FUNC_SEARCH, 31'd10007),   // shares the home slot of key zero
      cfg_row(15'd0, 15'd0),
      op_known(qpht_pkg::FUNC_SEARCH, 31'd5, qpht_pkg::ST_NOT_FOUND, 14'd0, 15'd1),
      op_known(qpht_pkg::FUNC_INSERT, 31'd5, qpht_pkg::ST_INSERT_FAILED, 14'd0, 15'd1),
      op_known(qpht_pkg::FUNC_SEARCH, 31'd0, qpht_pkg::ST_FOUND, 14'd0, 15'd1),
      cfg_row(15'd0, 15'd200),
      op_known(qpht_pkg::FUNC_INSERT, 31'd77, qpht_pkg::ST_INSERT_FAILED, 14'd0, 15'd200),
      op_known(qpht_pkg::FUNC_SEARCH, 31'd77, qpht_pkg::ST_NOT_FOUND, 14'd0, 15'd200),
      cfg_row(15'd0, 15'h7FFF),
      op_known(qpht_pkg::FUNC_INSERT, 31'd1, qpht_pkg::ST_INSERT_FAILED, 14'd0, 15'h7FFF),
      cfg_row(15'h7FFF, 15'd16384),
      op_known(qpht_pkg::FUNC_INSERT, 31'd16383, qpht_pkg::ST_INSERTED, 14'h3FFF, 15'd1),
      op_row(qpht_pkg::FUNC_INSERT, 31'h7FFF_FFFF), // home slot is the top one, now taken
      op_known(qpht_pkg::FUNC_SEARCH, 31'd16383, qpht_pkg::ST_FOUND, 14'h3FFF, 15'd1),
      cfg_row(15'd16384, 15'd1),
      op_row(qpht_pkg::FUNC_SEARCH, 31'h7FFF_FFFF),
      op_known(qpht_pkg::FUNC_INSERT, 31'd32767, qpht_pkg::ST_INSERT_FAILED, 14'd0, 15'd1),
      cfg_row(15'd1, 15'd3),
      op_known(qpht_pkg::FUNC_INSERT, 31'd9, qpht_pkg::ST_INSERT_FAILED, 14'd0, 15'd3)
    };

    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= qpht_pkg::CFG_TABLE_SIZE;
    cfg_wdata   <= '0;
    in_if.valid <= 1'b0;
    in_if.func  <= qpht_pkg::FUNC_INSERT;
    in_if.key   <= '0;

    // Reset state of the shadow: every slot empty, registers at their defaults.
    for (int s = 0; s < DEPTH; s++) begin
      shadow_occupied[s] = 1'b0;
      shadow_keys[s]     = '0;
    end
    shadow_size  = qpht_pkg::TABLE_SIZE_RST;
    shadow_limit = qpht_pkg::PROBE_LIMIT_RST;
    burst_left   = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // The block runs a clearing pass first; the first offer just waits on ready.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_settings(directed_rows[r].size_val, directed_rows[r].limit_val);
      end else begin
        offer(directed_rows[r].func, directed_rows[r].key, directed_rows[r].typed,
              directed_rows[r].want);
      end
    end

    // Random part: phases of fresh settings, each a random mix of inserts and
    // lookups of keys already stored, with some duplicates and misses.
    // The table is never emptied, so small settings fill up and start failing.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       size_val = REG_W'($urandom_range(0, 16));
        1, 2:    size_val = REG_W'($urandom_range(17, 127));
        3, 4, 5: size_val = REG_W'($urandom_range(128, 1500));
        6, 7:    size_val = REG_W'($urandom_range(1501, 16383));
        8:       size_val = REG_W'(DEPTH);
        default: size_val = REG_W'($urandom_range(DEPTH + 1, 32767));
      endcase
      // Keep long probe limits to large tables, where chains stay short.
      case ($urandom_range(0, 9))
        0:       limit_val = '0;
        1:       limit_val = REG_W'(1);
        8:       limit_val = (size_val > 1500) ? REG_W'($urandom_range(49, 300)) : REG_W'(48);
        9:       limit_val = (size_val >= 4096) ?
                             ($urandom_range(0, 1) ? REG_W'(DEPTH) : REG_W'(32767)) :
                             REG_W'(48);
        default: limit_val = REG_W'($urandom_range(2, 48));
      endcase
      write_settings(size_val, limit_val);
      phases_run++;

      phase_items = $urandom_range(50, 110);
      if (phase_items > RANDOM_ITEMS - random_sent) phase_items = RANDOM_ITEMS - random_sent;
      repeat (phase_items) begin
        pick = $urandom_range(0, 19);
        if (pick < 8 || inserted_keys.size() == 0) begin
          f = qpht_pkg::FUNC_INSERT;
          k = shaped_key();
          inserted_keys.push_back(k);
          if (inserted_keys.size() > KNOWN_KEYS_MAX) void'(inserted_keys.pop_front());
        end else if (pick < 15) begin
          f = qpht_pkg::FUNC_SEARCH;
          k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        end else if (pick < 17) begin
          f = qpht_pkg::FUNC_INSERT;
          k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        end else begin
          f = qpht_pkg::FUNC_SEARCH;
          k = shaped_key();
        end
        offer(f, k, 1'b0, '0);
        random_sent++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d items over %0d random settings; %0d inserted, %0d insert failed,",
             items_sent, phases_run, status_seen[qpht_pkg::ST_INSERTED],
             status_seen[qpht_pkg::ST_INSERT_FAILED]);
    $display("     %0d found, %0d not found; %0d results checked, %0d errors",
             status_seen[qpht_pkg::ST_FOUND], status_seen[qpht_pkg::ST_NOT_FOUND],
             results_checked, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: switch among stall patterns, with one long hold-off while the
  // sender is still offering, so the block stalls its input behind the result.
  // ---------------------------------------------------------------------------

  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit held;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && in_if.valid && results_checked >= HOLD_AFTER_RESULTS) begin
        held      = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking: each accepted result against the oldest pending expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_checked++;
      status_seen[out_if.status]++;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d slot %0d probe_count %0d",
               out_if.status, out_if.slot, out_if.probe_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          error_count++;
        end
        if (out_if.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_if.slot);
          error_count++;
        end
        if (out_if.probe_count !== want.probe_count) begin
          $error("probe_count: expected %0d, got %0d", want.probe_count, out_if.probe_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run, clearing pass included.
  initial begin
    #80_000_000;
    $display("timeout with %0d results still pending", pending_results.size());
    $display("tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/qpht_pkg.sv
hw/rtl/qpht_if.sv
hw/rtl/quadratic_probe_hash_table.sv
hw/rtl/qpht_checker.sv
dv/tb.sv
